[sv/r2fft_pkg.sv]
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants for the radix-2 DIF FFT unit
// Store word layout, data width and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package r2fft_pkg;

	localparam int DATA_BITS = 22;
	localparam int TW_BITS   = 17;

	typedef logic signed [DATA_BITS-1:0] data_t;
	typedef logic signed [TW_BITS-1:0]   tw_t;

	typedef struct packed {
		data_t im;
		data_t re;
	} cplx_t;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_RDA   = 7'b0000010,
		ST_RDB   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_WRB   = 7'b0010000,
		ST_EMRD  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	// cos(2*pi*k/64) in Q2.15, k = 0..16
	function automatic tw_t cos_q(input logic [4:0] k);
		case (k)
			5'd0:  cos_q = 17'sd32768;
			5'd1:  cos_q = 17'sd32610;
			5'd2:  cos_q = 17'sd32138;
			5'd3:  cos_q = 17'sd31357;
			5'd4:  cos_q = 17'sd30274;
			5'd5:  cos_q = 17'sd28899;
			5'd6:  cos_q = 17'sd27246;
			5'd7:  cos_q = 17'sd25330;
			5'd8:  cos_q = 17'sd23170;
			5'd9:  cos_q = 17'sd20788;
			5'd10: cos_q = 17'sd18205;
			5'd11: cos_q = 17'sd15447;
			5'd12: cos_q = 17'sd12540;
			5'd13: cos_q = 17'sd9512;
			5'd14: cos_q = 17'sd6393;
			5'd15: cos_q = 17'sd3212;
			default: cos_q = 17'sd0;
		endcase
	endfunction

	// full-circle cosine, 64 steps per turn
	function automatic tw_t rom_cos(input logic [5:0] k);
		if (k <= 6'd16)
			rom_cos = cos_q(k[4:0]);
		else if (k <= 6'd32)
			rom_cos = -cos_q(5'(6'd32 - k));
		else if (k <= 6'd48)
			rom_cos = -cos_q(5'(k - 6'd32));
		else
			rom_cos = cos_q(5'(7'd64 - {1'b0, k}));
	endfunction

	// saturate a wide signed value to DATA_BITS
	function automatic data_t sat(input logic signed [47:0] v);
		if (v > 48'sd2097151)
			sat = 22'sh1FFFFF;
		else if (v < -48'sd2097152)
			sat = 22'sh200000;
		else
			sat = v[DATA_BITS-1:0];
	endfunction

endpackage

[sv/radix2_dif_fft_unit.sv]
// ----------------------------------------------------------------------------
// radix2_dif_fft_unit: in-place radix-2 decimation-in-frequency FFT
// Loads a frame, transforms it in one store, streams bins in memory order.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_axis  | in  | tvalid/tready       | tdata: sample_real, sample_imag
//  m_axis  | out | tvalid/tready/tlast | tdata: result_real, result_imag;
//          |     |                     | tuser: bin_index
//
// Load accepts a sample whenever one is offered. Each butterfly steps through
// read a, read b, multiply and write b (a+b is written during the multiply
// step), all through the single store port. Each emit is a store read, an
// output register load, then the transfer. Input is refused from the last
// sample until the final result transfers. Output stalls hold the emit
// sequencer. Reset clears the sequencer and counters; the store needs no
// clearing.
module radix2_dif_fft_unit #(
	parameter int POINTS      = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] sample_real, [31:16] sample_imag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [21:0] result_real, [43:22] result_imag
	output logic [5:0]  m_axis_tuser,   // [5:0] bin_index
	output logic        m_axis_tlast
);

	localparam int LOGP = $clog2(POINTS + 1) - 1;        // floor(log2 POINTS)
	localparam int AW   = (POINTS > 1) ? $clog2(POINTS) : 1;

	// span of each stage; unused stages get a harmless nonzero span
	localparam int SP1 = ((POINTS >> 1) > 1) ? (POINTS >> 1) : 2;
	localparam int SP2 = ((POINTS >> 2) > 1) ? (POINTS >> 2) : 2;
	localparam int SP3 = ((POINTS >> 3) > 1) ? (POINTS >> 3) : 2;
	localparam int SP4 = ((POINTS >> 4) > 1) ? (POINTS >> 4) : 2;
	localparam int SP5 = ((POINTS >> 5) > 1) ? (POINTS >> 5) : 2;

	// twiddle step per butterfly: 64/span as quotient and remainder
	localparam logic [5:0] KINC [6] = '{6'(64 / POINTS), 6'(64 / SP1), 6'(64 / SP2),
		6'(64 / SP3), 6'(64 / SP4), 6'(64 / SP5)};
	localparam logic [6:0] KREM [6] = '{7'(64 % POINTS), 7'(64 % SP1), 7'(64 % SP2),
		7'(64 % SP3), 7'(64 % SP4), 7'(64 % SP5)};

	r2fft_pkg::state_t state_q;

	// single-port store
	r2fft_pkg::cplx_t mem [POINTS];
	r2fft_pkg::cplx_t rd_data;
	logic             we;
	logic [AW-1:0]    addr;
	r2fft_pkg::cplx_t wdata;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rd_data <= mem[addr];
	end

	logic [AW-1:0] pos_q;        // load / emit position
	logic [6:0]    span_q;       // current span
	logic [2:0]    st_q;         // stage number
	logic [6:0]    blk_q;        // block base
	logic [6:0]    j_q;          // index in block
	logic [5:0]    k_q;          // twiddle index, j*64/span
	logic [6:0]    rem_q;        // remainder of j*64/span
	r2fft_pkg::cplx_t a_q;
	r2fft_pkg::tw_t     wr_q, wi_q;
	logic signed [39:0] p1_q, p2_q, p3_q, p4_q;

	wire [6:0] half = span_q >> 1;
	wire [6:0] p_ix = blk_q + j_q;
	wire [6:0] q_ix = p_ix + half;
	wire [5:0] kw   = k_q;

	// step the twiddle index by 64/span, carrying the remainder
	wire [6:0] rem_sum = rem_q + KREM[st_q];
	wire       k_carry = (rem_sum >= span_q);
	wire [6:0] rem_nx  = k_carry ? rem_sum - span_q : rem_sum;
	wire [5:0] k_nx    = k_q + KINC[st_q] + {5'd0, k_carry};

	// a - b, exact, while b is on the read port
	wire signed [22:0] dr_w = 23'(a_q.re) - 23'(rd_data.re);
	wire signed [22:0] di_w = 23'(a_q.im) - 23'(rd_data.im);

	// sample sign extension / saturation
	function automatic r2fft_pkg::data_t load_cv(input logic [15:0] raw);
		logic [23:0]        rz;
		logic signed [47:0] v;
		rz = 24'(raw);
		v  = 48'(signed'(rz[SAMPLE_BITS-1:0]));
		return r2fft_pkg::sat(v);
	endfunction

	function automatic logic signed [47:0] rnd(input logic signed [40:0] v);
		return 48'((v + 41'sd16384) >>> 15);
	endfunction

	// bit reversal of the low LOGP bits
	function automatic logic [5:0] bin_of(input logic [AW-1:0] p);
		logic [5:0] r;
		logic [5:0] pp;
		pp = 6'(p);
		r  = pp;
		for (int b = 0; b < LOGP; b++)
			r[LOGP-1-b] = pp[b];
		return r;
	endfunction

	logic s_acc, m_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == r2fft_pkg::ST_LOAD);

	always_comb begin
		we    = 1'b0;
		addr  = pos_q;
		wdata = '0;
		case (state_q)
			r2fft_pkg::ST_LOAD: begin
				we    = s_acc;
				wdata = '{im: load_cv(s_axis_tdata[31:16]), re: load_cv(s_axis_tdata[15:0])};
			end
			r2fft_pkg::ST_RDA: addr = AW'(p_ix);
			r2fft_pkg::ST_RDB: addr = AW'(q_ix);
			r2fft_pkg::ST_MUL: begin
				we    = 1'b1;
				addr  = AW'(p_ix);
				wdata = '{im: r2fft_pkg::sat(48'(a_q.im) + 48'(rd_data.im)),
				          re: r2fft_pkg::sat(48'(a_q.re) + 48'(rd_data.re))};
			end
			r2fft_pkg::ST_WRB: begin
				we    = 1'b1;
				addr  = AW'(q_ix);
				wdata = '{im: r2fft_pkg::sat(rnd(41'(p3_q) + 41'(p4_q))),
				          re: r2fft_pkg::sat(rnd(41'(p1_q) - 41'(p2_q)))};
			end
			default: addr = pos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= r2fft_pkg::ST_LOAD;
			pos_q         <= '0;
			span_q        <= 7'(POINTS);
			st_q          <= '0;
			blk_q         <= '0;
			j_q           <= '0;
			k_q           <= '0;
			rem_q         <= '0;
			a_q           <= '0;
			wr_q          <= '0;
			wi_q          <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			case (state_q)
				r2fft_pkg::ST_LOAD: begin
					if (s_acc) begin
						if (32'(pos_q) == POINTS - 1) begin
							pos_q  <= '0;
							span_q <= 7'(POINTS);
							st_q   <= '0;
							blk_q  <= '0;
							j_q    <= '0;
							k_q    <= '0;
							rem_q  <= '0;
							state_q <= (POINTS > 1) ? r2fft_pkg::ST_RDA : r2fft_pkg::ST_EMRD;
						end else
							pos_q <= pos_q + 1'b1;
					end
				end
				r2fft_pkg::ST_RDA: begin
					wr_q    <= r2fft_pkg::rom_cos(kw);
					wi_q    <= -r2fft_pkg::rom_cos(kw + 6'd48);
					state_q <= r2fft_pkg::ST_RDB;
				end
				r2fft_pkg::ST_RDB: begin
					a_q     <= rd_data;
					state_q <= r2fft_pkg::ST_MUL;
				end
				r2fft_pkg::ST_MUL: begin
					state_q <= r2fft_pkg::ST_WRB;
				end
				r2fft_pkg::ST_WRB: begin
					// next butterfly indices
					if (j_q + 7'd1 < half) begin
						j_q   <= j_q + 7'd1;
						k_q   <= k_nx;
						rem_q <= rem_nx;
					end else begin
						j_q   <= '0;
						k_q   <= '0;
						rem_q <= '0;
						if (8'(blk_q) + 8'(span_q) + 8'(span_q) <= 8'(POINTS))
							blk_q <= blk_q + span_q;
						else begin
							blk_q  <= '0;
							span_q <= span_q >> 1;
							st_q   <= st_q + 3'd1;
						end
					end
					if (j_q + 7'd1 >= half &&
					    !(8'(blk_q) + 8'(span_q) + 8'(span_q) <= 8'(POINTS)) &&
					    (span_q >> 1) <= 7'd1)
						state_q <= r2fft_pkg::ST_EMRD;
					else
						state_q <= r2fft_pkg::ST_RDA;
				end
				r2fft_pkg::ST_EMRD: begin
					state_q <= r2fft_pkg::ST_EMIT;
				end
				r2fft_pkg::ST_EMIT: begin
					if (!m_axis_tvalid) begin
						m_axis_tdata  <= {4'd0, rd_data.im, rd_data.re};
						m_axis_tuser  <= bin_of(pos_q);
						m_axis_tlast  <= (32'(pos_q) == POINTS - 1);
						m_axis_tvalid <= 1'b1;
					end else if (m_acc) begin
						m_axis_tvalid <= 1'b0;
						if (32'(pos_q) == POINTS - 1) begin
							pos_q   <= '0;
							state_q <= r2fft_pkg::ST_LOAD;
						end else begin
							pos_q   <= pos_q + 1'b1;
							state_q <= r2fft_pkg::ST_EMRD;
						end
					end
				end
				default: state_q <= r2fft_pkg::ST_LOAD;
			endcase
		end
	end

	// products of (a-b) and the twiddle, registered at the end of the multiply
	// cycle and consumed by the write-b cycle
	always_ff @(posedge clk) begin
		if (state_q == r2fft_pkg::ST_MUL) begin
			p1_q <= 40'(dr_w) * 40'(wr_q);
			p2_q <= 40'(di_w) * 40'(wi_q);
			p3_q <= 40'(dr_w) * 40'(wi_q);
			p4_q <= 40'(di_w) * 40'(wr_q);
		end
	end

`ifndef SYNTHESIS
	a_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("input open while emitting");
	a_last_ret: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_axis_tlast) |=> s_axis_tready) else $error("no return to load");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output changed under stall");
`endif

endmodule

[tb/sv/radix2_dif_fft_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix2_dif_fft_unit_tb: self-checking bench for the radix-2 DIF FFT unit
// Streams 64-sample frames in, computes the transform of each frame in a
// fixed-point predictor, checks every bin, index and last flag that comes out.
// ----------------------------------------------------------------------------
module radix2_dif_fft_unit_tb;

	localparam int NPTS      = 64;
	localparam int LIMIT_CYC = 400000;

	typedef struct packed {
		logic [21:0] re;
		logic [21:0] im;
		logic [5:0]  bin;
		logic        last;
	} bin_t;

	// cos(2*pi*k/64) quarter table, Q2.15
	localparam int COSQ [0:16] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246,
		25330, 23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

	class fft_scoreboard;
		longint frame_re [NPTS];
		longint frame_im [NPTS];
		int     fill;
		bin_t   pending [$];
		int     errors;
		int     bins_checked;

		function new();
			fill = 0;
			errors = 0;
			bins_checked = 0;
		endfunction

		function longint clip22(longint v);
			if (v > 2097151) return 2097151;
			if (v < -2097152) return -2097152;
			return v;
		endfunction

		function longint rnd15(longint v);
			v = v + 16384;
			return v >>> 15;
		endfunction

		function longint cos64(int k);
			k = k & 63;
			if (k <= 16) return COSQ[k];
			if (k <= 32) return -COSQ[32 - k];
			if (k <= 48) return -COSQ[k - 32];
			return COSQ[64 - k];
		endfunction

		function void transform();
			int span, half, p, q, k;
			longint wr, wi, ar, ai, br, bi, dr, di;
			span = NPTS;
			while (span > 1) begin
				half = span / 2;
				for (int blk = 0; blk < NPTS / span; blk++) begin
					for (int j = 0; j < half; j++) begin
						p = blk * span + j;
						q = p + half;
						k = (j * 64) / span;
						wr = cos64(k);
						wi = -cos64(k + 48);
						ar = frame_re[p]; ai = frame_im[p];
						br = frame_re[q]; bi = frame_im[q];
						dr = ar - br; di = ai - bi;
						frame_re[p] = clip22(ar + br);
						frame_im[p] = clip22(ai + bi);
						frame_re[q] = clip22(rnd15(dr * wr - di * wi));
						frame_im[q] = clip22(rnd15(dr * wi + di * wr));
					end
				end
				span = span / 2;
			end
		endfunction

		// note one accepted sample; the 64th closes the frame
		function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
			bin_t b;
			frame_re[fill] = re;
			frame_im[fill] = im;
			fill++;
			if (fill == NPTS) begin
				fill = 0;
				transform();
				for (int n = 0; n < NPTS; n++) begin
					b.re = frame_re[n][21:0];
					b.im = frame_im[n][21:0];
					for (int i = 0; i < 6; i++) b.bin[5 - i] = n[i];
					b.last = (n == NPTS - 1);
					pending.push_back(b);
				end
			end
		endfunction

		task report(string what, logic [47:0] got, logic [47:0] want);
			errors++;
			if (errors <= 30)
				$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		endtask

		task check_bin(logic [47:0] data, logic [5:0] bin, logic last);
			bin_t w;
			if (pending.size() == 0) begin
				report("unexpected bin", data, 48'd0);
				return;
			end
			w = pending.pop_front();
			bins_checked++;
			if (data[21:0] !== w.re) report("result_real", 48'(data[21:0]), 48'(w.re));
			if (data[43:22] !== w.im) report("result_imag", 48'(data[43:22]), 48'(w.im));
			if (bin !== w.bin) report("bin_index", 48'(bin), 48'(w.bin));
			if (last !== w.last) report("last_result", 48'(last), 48'(w.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [5:0]  m_axis_tuser;
	logic        m_axis_tlast;

	fft_scoreboard sb = new();
	int send_idle_pct  = 0;   // chance (of 100) the sender idles a cycle
	int recv_stall_pct = 0;   // chance (of 100) the receiver stalls a cycle
	int samples_sent   = 0;
	int cycle_count    = 0;

	radix2_dif_fft_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYC) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("radix2_dif_fft_unit test failed");
			$finish;
		end
	end

	// result side: sample at the edge, then redraw the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_bin(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one sample transfer, with optional random idle cycles before it;
	// valid stays high between back-to-back transfers
	task automatic send_sample(logic [15:0] re, logic [15:0] im);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {im, re};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(re, im);
		samples_sent++;
	endtask

	// random frame; flavor picks full-scale, small or mixed content
	task automatic send_frame(int flavor);
		logic [15:0] re, im;
		for (int n = 0; n < NPTS; n++) begin
			case (flavor)
				0: begin
					re = 16'($urandom()); im = 16'($urandom());
				end
				1: begin
					re = 16'($signed($urandom_range(200)) - 100);
					im = 16'($signed($urandom_range(200)) - 100);
				end
				default: begin
					re = $urandom_range(1) ? 16'h7fff : 16'h8000;
					im = $urandom_range(3) == 0 ? 16'h8000 : 16'($urandom());
				end
			endcase
			send_sample(re, im);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: impulse of full positive real and full negative imaginary scale, then full negative DC
		for (int n = 0; n < NPTS; n++)
			send_sample(n == 0 ? 16'h7fff : 16'h0000, n == 0 ? 16'h8000 : 16'h0000);
		for (int n = 0; n < NPTS; n++)
			send_sample(16'h8000, 16'h8000);
		drain();   // sender holds off until every bin is back

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 25 : 0;
			recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 25 : 0;
			for (int f = 0; f < 1; f++) begin
				if (ph == 0 && f == 0) send_idle_pct = 0;
				send_frame($urandom_range(2));
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		$display("sent %0d samples in %0d frames, checked %0d bins",
			samples_sent, samples_sent / NPTS, sb.bins_checked);
		$display("covered impulse, full-scale DC, saturating and small random frames");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("radix2_dif_fft_unit test passed");
		else
			$display("radix2_dif_fft_unit test failed");
		$finish;
	end
endmodule
